// File: design/tmd_pkg.sv
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared types and constants for the three-material decomposition block.
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int unsigned IndexBitsDef = 16;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned IdxW         = 16;
  localparam int unsigned CoefW        = 24;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned DiffW        = 25;
  localparam int unsigned ProdW        = 50;
  localparam int unsigned NumW         = 51;
  localparam int unsigned NcW          = 53;
  localparam int unsigned MagW         = 64;
  localparam int unsigned FracW        = 8;
  localparam int unsigned DivStages    = FracW + 1;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoLvlW     = $clog2(FifoDepth + 1);
  localparam int unsigned BusyLevel    = FifoDepth - 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A_LOW,
    REG_COEF_B_LOW,
    REG_COEF_C_LOW,
    REG_COEF_A_HIGH,
    REG_COEF_B_HIGH,
    REG_COEF_C_HIGH,
    REG_MIX_RATIO,
    REG_INDEX_BASE
  } tmd_reg_e;

  typedef struct packed {
    logic signed [CoefW-1:0] cal;
    logic signed [CoefW-1:0] cbl;
    logic signed [CoefW-1:0] ccl;
    logic signed [CoefW-1:0] cah;
    logic signed [CoefW-1:0] cbh;
    logic signed [CoefW-1:0] cch;
    logic [15:0]             mix;
    logic [IdxW-1:0]         base;
  } tmd_cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] blended;
    logic [IdxW-1:0]           dest;
    logic                      singular;
  } tmd_meta_t;

  typedef struct packed {
    logic signed [NumW-1:0] na;
    logic signed [NumW-1:0] nb;
    logic signed [NumW-1:0] det;
    tmd_meta_t              meta;
  } tmd_entry_t;

endpackage

// File: design/three_material_decomposition.sv
// ----------------------------------------------------------------------------
// three_material_decomposition
// Dual-energy three-material decomposition with blend and index remap.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while busy is low, set by the fully pipelined 9-stage divider.
// busy only rises if the front/back queue backs up; the receiver cannot stall.
// Reset: asynchronous, clears all valid flags and loads register defaults.
module three_material_decomposition import tmd_pkg::*; #(
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [SampleW-1:0] low_sample_i,
  input  logic signed [SampleW-1:0] high_sample_i,
  input  logic [IdxW-1:0]           sample_index_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CoefW-1:0]          cfg_wdata_i,
  output logic                      valid_o,
  output logic [FracW-1:0]          frac_a_o,
  output logic [FracW-1:0]          frac_b_o,
  output logic [FracW-1:0]          frac_c_o,
  output logic signed [SampleW-1:0] blended_o,
  output logic [IdxW-1:0]           dest_index_o,
  output logic                      singular_o
);

  localparam tmd_cfg_t CfgReset = '{mix: 16'd16384, default: '0};

  tmd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (tmd_reg_e'(cfg_idx_i))
        REG_COEF_A_LOW:  cfg_q.cal  <= cfg_wdata_i;
        REG_COEF_B_LOW:  cfg_q.cbl  <= cfg_wdata_i;
        REG_COEF_C_LOW:  cfg_q.ccl  <= cfg_wdata_i;
        REG_COEF_A_HIGH: cfg_q.cah  <= cfg_wdata_i;
        REG_COEF_B_HIGH: cfg_q.cbh  <= cfg_wdata_i;
        REG_COEF_C_HIGH: cfg_q.cch  <= cfg_wdata_i;
        REG_MIX_RATIO:   cfg_q.mix  <= cfg_wdata_i[15:0];
        REG_INDEX_BASE:  cfg_q.base <= cfg_wdata_i[IdxW-1:0];
        default:         cfg_q      <= cfg_q;
      endcase
    end
  end

  logic                accept, push, pop, empty;
  tmd_entry_t          push_entry, pop_entry;
  logic [FifoLvlW-1:0] level;

  assign busy   = (level >= FifoLvlW'(BusyLevel));
  assign accept = start && !busy;

  tmd_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .low_sample_i   (low_sample_i),
    .high_sample_i  (high_sample_i),
    .sample_index_i (sample_index_i),
    .cfg_i          (cfg_q),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  tmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty),
    .level_o (level)
  );

  tmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .frac_a_o     (frac_a_o),
    .frac_b_o     (frac_b_o),
    .frac_c_o     (frac_c_o),
    .blended_o    (blended_o),
    .dest_index_o (dest_index_o),
    .singular_o   (singular_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##15 valid_o)
    else $error("transaction result missing at expected latency");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 15))
    else $error("result without matching transaction");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && singular_o) |-> (frac_a_o == '0 && frac_b_o == '0 && frac_c_o == '0))
    else $error("singular result with nonzero fractions");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (level != FifoLvlW'(FifoDepth)))
    else $error("queue overflow");

endmodule

// File: design/tmd_front.sv
// ----------------------------------------------------------------------------
// tmd_front
// Accepts pixels, forms the Cramer numerators, determinant, blend and index.
// ----------------------------------------------------------------------------
module tmd_front import tmd_pkg::*; #(
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic signed [SampleW-1:0] low_sample_i,
  input  logic signed [SampleW-1:0] high_sample_i,
  input  logic [IdxW-1:0]           sample_index_i,
  input  tmd_cfg_t                  cfg_i,
  output logic                      push_o,
  output tmd_entry_t                entry_o
);

  localparam logic [IdxW-1:0] IdxMask = (INDEX_BITS >= IdxW) ? {IdxW{1'b1}} :
                                        IdxW'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [15:0] MixOne = 16'd32768;

  logic signed [DiffW-1:0] alpha, beta, gamma, delta, t_d, p_d;
  logic [15:0]             r_d, rinv_d;
  logic [IdxW-1:0]         dest_d;

  assign alpha = DiffW'(cfg_i.cal) - DiffW'(cfg_i.ccl);
  assign beta  = DiffW'(cfg_i.cbl) - DiffW'(cfg_i.ccl);
  assign gamma = DiffW'(cfg_i.cah) - DiffW'(cfg_i.cch);
  assign delta = DiffW'(cfg_i.cbh) - DiffW'(cfg_i.cch);
  assign t_d = DiffW'($signed({low_sample_i, 8'h00}))  - DiffW'(cfg_i.ccl);
  assign p_d = DiffW'($signed({high_sample_i, 8'h00})) - DiffW'(cfg_i.cch);
  assign r_d    = (cfg_i.mix > MixOne) ? MixOne : cfg_i.mix;
  assign rinv_d = MixOne - r_d;
  assign dest_d = ((cfg_i.base != '0) ? (cfg_i.base - sample_index_i) : sample_index_i)
                  & IdxMask;

  // stage 1
  logic                      v1_q;
  logic signed [DiffW-1:0]   t_q, p_q;
  logic signed [SampleW-1:0] theta_q, phi_q;
  logic [15:0]               r_q, rinv_q;
  logic [IdxW-1:0]           dest1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    p_q     <= p_d;
    theta_q <= low_sample_i;
    phi_q   <= high_sample_i;
    r_q     <= r_d;
    rinv_q  <= rinv_d;
    dest1_q <= dest_d;
  end

  // stage 2: products
  logic                    v2_q;
  logic signed [ProdW-1:0] td_q, bp_q, ap_q, gt_q, ad_q, bg_q;
  logic signed [32:0]      wl_q, wh_q;
  logic [IdxW-1:0]         dest2_q;
  logic signed [ProdW-1:0] td_d, bp_d, ap_d, gt_d, ad_d, bg_d;
  logic signed [32:0]      wl_d, wh_d;

  assign td_d = t_q * delta;
  assign bp_d = beta * p_q;
  assign ap_d = alpha * p_q;
  assign gt_d = gamma * t_q;
  assign ad_d = alpha * delta;
  assign bg_d = beta * gamma;
  assign wl_d = theta_q * $signed({1'b0, r_q});
  assign wh_d = phi_q * $signed({1'b0, rinv_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    td_q    <= td_d;
    bp_q    <= bp_d;
    ap_q    <= ap_d;
    gt_q    <= gt_d;
    ad_q    <= ad_d;
    bg_q    <= bg_d;
    wl_q    <= wl_d;
    wh_q    <= wh_d;
    dest2_q <= dest1_q;
  end

  // stage 3: differences, blend divide and saturate, classify
  logic signed [NumW-1:0] det;
  logic signed [33:0]     bsum, badj;
  logic signed [18:0]     bq;
  logic signed [SampleW-1:0] blend;

  assign det  = NumW'(ad_q) - NumW'(bg_q);
  assign bsum = 34'(wl_q) + 34'(wh_q);
  assign badj = bsum[33] ? (bsum + 34'sd32767) : bsum;
  assign bq   = 19'(badj >>> 15);

  always_comb begin
    if (bq > 19'sd32767) begin
      blend = 16'sh7fff;
    end else if (bq < -19'sd32768) begin
      blend = -16'sh8000;
    end else begin
      blend = bq[15:0];
    end
  end

  assign push_o                = v2_q;
  assign entry_o.na            = NumW'(td_q) - NumW'(bp_q);
  assign entry_o.nb            = NumW'(ap_q) - NumW'(gt_q);
  assign entry_o.det           = det;
  assign entry_o.meta.blended  = blend;
  assign entry_o.meta.dest     = dest2_q;
  assign entry_o.meta.singular = (det == '0);

endmodule

// File: design/tmd_fifo.sv
// ----------------------------------------------------------------------------
// tmd_fifo
// Short queue between the front and back sections.
// ----------------------------------------------------------------------------
module tmd_fifo import tmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tmd_entry_t          data_i,
  input  logic                pop_i,
  output tmd_entry_t          data_o,
  output logic                empty_o,
  output logic [FifoLvlW-1:0] level_o
);

  tmd_entry_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoLvlW-1:0] lvl_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      lvl_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        lvl_q <= lvl_q + 1'b1;
      end else if (pop_i && !push_i) begin
        lvl_q <= lvl_q - 1'b1;
      end
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (lvl_q == '0);
  assign level_o = lvl_q;

endmodule

// File: design/tmd_div.sv
// ----------------------------------------------------------------------------
// tmd_div
// Pipelined restoring divider, one quotient bit per stage, clamped to 8 bits.
// ----------------------------------------------------------------------------
module tmd_div import tmd_pkg::*; (
  input  logic             clk_i,
  input  logic [MagW-1:0]  num_i,
  input  logic [MagW-1:0]  den_i,
  input  logic             zero_i,
  output logic [FracW-1:0] frac_o
);

  logic [MagW-1:0]  rem_q [DivStages];
  logic [MagW-1:0]  den_q [DivStages];
  logic [FracW-1:0] quo_q [DivStages];
  logic             sat_q [DivStages];
  logic             zero_q [DivStages];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    sat_q[0]  <= (num_i >= (den_i << FracW));
    zero_q[0] <= zero_i;
    for (int j = 1; j < DivStages; j++) begin
      den_q[j]  <= den_q[j-1];
      sat_q[j]  <= sat_q[j-1];
      zero_q[j] <= zero_q[j-1];
      if (rem_q[j-1] >= (den_q[j-1] << (DivStages - 1 - j))) begin
        rem_q[j] <= rem_q[j-1] - (den_q[j-1] << (DivStages - 1 - j));
        quo_q[j] <= quo_q[j-1] | (FracW'(1) << (DivStages - 1 - j));
      end else begin
        rem_q[j] <= rem_q[j-1];
        quo_q[j] <= quo_q[j-1];
      end
    end
  end

  assign frac_o = zero_q[DivStages-1] ? '0 :
                  sat_q[DivStages-1]  ? {FracW{1'b1}} : quo_q[DivStages-1];

endmodule

// File: design/tmd_back.sv
// ----------------------------------------------------------------------------
// tmd_back
// Drains the queue, scales the numerators and divides by the determinant.
// ----------------------------------------------------------------------------
module tmd_back import tmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  tmd_entry_t                entry_i,
  output logic                      pop_o,
  output logic                      valid_o,
  output logic [FracW-1:0]          frac_a_o,
  output logic [FracW-1:0]          frac_b_o,
  output logic [FracW-1:0]          frac_c_o,
  output logic signed [SampleW-1:0] blended_o,
  output logic [IdxW-1:0]           dest_index_o,
  output logic                      singular_o
);

  assign pop_o = !empty_i;

  // stage 1
  logic                   vb1_q;
  logic signed [NcW-1:0]  n1_q [3];
  logic signed [NumW-1:0] det1_q;
  tmd_meta_t              m1_q;

  always_ff @(posedge clk_i) begin
    n1_q[0] <= NcW'(entry_i.na);
    n1_q[1] <= NcW'(entry_i.nb);
    n1_q[2] <= NcW'(entry_i.det) - NcW'(entry_i.na) - NcW'(entry_i.nb);
    det1_q  <= entry_i.det;
    m1_q    <= entry_i.meta;
  end

  // stage 2: scale by 255, split sign and magnitude
  logic            vb2_q;
  logic [MagW-1:0] mag_q [3];
  logic            zero_q [3];
  logic [MagW-1:0] den_q;
  tmd_meta_t       m2_q;
  logic signed [MagW-1:0] detx;

  assign detx = MagW'(det1_q);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [MagW-1:0] sx, sc;
      sx = MagW'(n1_q[i]);
      sc = (sx <<< FracW) - sx;
      mag_q[i]  <= sc[MagW-1] ? MagW'(-sc) : MagW'(sc);
      zero_q[i] <= (sc[MagW-1] ^ detx[MagW-1]) | m1_q.singular;
    end
    den_q <= detx[MagW-1] ? MagW'(-detx) : MagW'(detx);
    m2_q  <= m1_q;
  end

  logic [FracW-1:0] frac [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tmd_div u_div (
      .clk_i  (clk_i),
      .num_i  (mag_q[g]),
      .den_i  (den_q),
      .zero_i (zero_q[g]),
      .frac_o (frac[g])
    );
  end

  logic      vs_q [DivStages];
  tmd_meta_t ms_q [DivStages];

  always_ff @(posedge clk_i) begin
    ms_q[0] <= m2_q;
    for (int j = 1; j < DivStages; j++) begin
      ms_q[j] <= ms_q[j-1];
    end
    frac_a_o     <= frac[0];
    frac_b_o     <= frac[1];
    frac_c_o     <= frac[2];
    blended_o    <= ms_q[DivStages-1].blended;
    dest_index_o <= ms_q[DivStages-1].dest;
    singular_o   <= ms_q[DivStages-1].singular;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q   <= 1'b0;
      vb2_q   <= 1'b0;
      valid_o <= 1'b0;
      for (int j = 0; j < DivStages; j++) begin
        vs_q[j] <= 1'b0;
      end
    end else begin
      vb1_q   <= pop_o;
      vb2_q   <= vb1_q;
      vs_q[0] <= vb2_q;
      for (int j = 1; j < DivStages; j++) begin
        vs_q[j] <= vs_q[j-1];
      end
      valid_o <= vs_q[DivStages-1];
    end
  end

endmodule

// File: test/three_material_decomposition_tb.sv
// ----------------------------------------------------------------------------
// three_material_decomposition_tb
// Streams pixel pairs through the decomposition block under several coefficient
// and blend settings and idle patterns, and checks every output transaction
// against a bit-accurate Cramer's-rule predictor held in the bench.
// ----------------------------------------------------------------------------
module three_material_decomposition_tb import tmd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]         fa;
    logic [7:0]         fb;
    logic [7:0]         fc;
    logic signed [15:0] blend;
    logic [15:0]        dest;
    logic               sing;
  } pixel_res_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic signed [SampleW-1:0] low_sample_i;
  logic signed [SampleW-1:0] high_sample_i;
  logic [IdxW-1:0]           sample_index_i;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_idx_i;
  logic [CoefW-1:0]          cfg_wdata_i;
  logic                      valid_o;
  logic [FracW-1:0]          frac_a_o;
  logic [FracW-1:0]          frac_b_o;
  logic [FracW-1:0]          frac_c_o;
  logic signed [SampleW-1:0] blended_o;
  logic [IdxW-1:0]           dest_index_o;
  logic                      singular_o;

  three_material_decomposition uut (.*);

  logic signed [23:0] coef [6];
  logic [15:0]        mix_q;
  logic [15:0]        base_q;
  pixel_res_t         pending_pixels[$];
  int                 errors;
  int                 idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] scale_frac(longint num, longint det);
    longint q;
    q = (num * 255) / det;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic pixel_res_t decompose(logic signed [15:0] lo,
                                           logic signed [15:0] hi,
                                           logic [15:0] idx);
    pixel_res_t res;
    longint al, be, ga, de, t, p, det, na, nb, r, bl;
    al  = longint'(coef[0]) - longint'(coef[2]);
    be  = longint'(coef[1]) - longint'(coef[2]);
    ga  = longint'(coef[3]) - longint'(coef[5]);
    de  = longint'(coef[4]) - longint'(coef[5]);
    t   = longint'(lo) * 256 - longint'(coef[2]);
    p   = longint'(hi) * 256 - longint'(coef[5]);
    det = al * de - be * ga;
    if (det == 0) begin
      res.fa = '0; res.fb = '0; res.fc = '0; res.sing = 1'b1;
    end else begin
      na = t * de - be * p;
      nb = al * p - ga * t;
      res.fa = scale_frac(na, det);
      res.fb = scale_frac(nb, det);
      res.fc = scale_frac(det - na - nb, det);
      res.sing = 1'b0;
    end
    r = (mix_q > 16'd32768) ? 32768 : longint'(mix_q);
    bl = (longint'(lo) * r + longint'(hi) * (32768 - r)) / 32768;
    if (bl > 32767) bl = 32767;
    if (bl < -32768) bl = -32768;
    res.blend = bl[15:0];
    res.dest = (base_q != 0) ? base_q - idx : idx;
    return res;
  endfunction

  task automatic write_reg(tmd_reg_e idx, logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx <= REG_COEF_C_HIGH) coef[idx] = val;
    else if (idx == REG_MIX_RATIO) mix_q = val[15:0];
    else base_q = val[15:0];
  endtask

  task automatic set_coefs(logic [23:0] cal, logic [23:0] cbl, logic [23:0] ccl,
                           logic [23:0] cah, logic [23:0] cbh, logic [23:0] cch);
    write_reg(REG_COEF_A_LOW, cal);
    write_reg(REG_COEF_B_LOW, cbl);
    write_reg(REG_COEF_C_LOW, ccl);
    write_reg(REG_COEF_A_HIGH, cah);
    write_reg(REG_COEF_B_HIGH, cbh);
    write_reg(REG_COEF_C_HIGH, cch);
  endtask

  task automatic drain();
    start    <= 1'b0;
    cfg_we_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [15:0] lo, logic [15:0] hi, logic [15:0] idx);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    low_sample_i   <= lo;
    high_sample_i  <= hi;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_pixels.push_back(decompose(lo, hi, idx));
  endtask

  // fractions near physical range: mixtures of the three coefficient columns
  task automatic send_mixture();
    int a, b;
    longint lo, hi;
    a  = $urandom_range(256);
    b  = $urandom_range(256 - a);
    lo = (a * longint'(coef[0]) + b * longint'(coef[1])
          + (256 - a - b) * longint'(coef[2])) / 65536;
    hi = (a * longint'(coef[3]) + b * longint'(coef[4])
          + (256 - a - b) * longint'(coef[5])) / 65536;
    send_pixel(lo[15:0], hi[15:0], 16'($urandom));
  endtask

  task automatic test_directed();
    logic [15:0] ext [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    idle_pct = 0;
    // singular: all coefficients zero after reset
    send_pixel(16'h1234, 16'h8000, 16'h0000);
    send_pixel(16'h7fff, 16'h7fff, 16'hffff);
    drain();
    set_coefs(24'd25600, 24'd5120, 24'd0, 24'd12800, 24'd10240, 24'd0);
    write_reg(REG_MIX_RATIO, 24'd32768);
    write_reg(REG_INDEX_BASE, 24'hffff);
    foreach (ext[i]) foreach (ext[j]) send_pixel(ext[i], ext[j], ext[(i + j) % 4]);
    send_pixel(16'd50, 16'd30, 16'd1);
    drain();
    write_reg(REG_MIX_RATIO, 24'hffff);
    write_reg(REG_INDEX_BASE, 24'd0);
    send_pixel(16'h8000, 16'h7fff, 16'h1234);
    drain();
    set_coefs(24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
    write_reg(REG_MIX_RATIO, 24'd0);
    send_pixel(16'h8000, 16'h8000, 16'hffff);
    send_pixel(16'h7fff, 16'h8000, 16'h0000);
    drain();
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) != 0) send_mixture();
      else send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
    end
    idle_pct = 0;
    drain();
  endtask

  task automatic random_config();
    set_coefs(24'($urandom_range(1, 16'hffff)), 24'($urandom),
              24'($urandom_range(0, 4096)), 24'($urandom),
              24'($urandom_range(1, 16'hffff)), 24'($urandom));
    write_reg(REG_MIX_RATIO, 24'($urandom_range(32768)));
    write_reg(REG_INDEX_BASE, $urandom_range(1) ? 24'($urandom & 32'hffff) : 24'd0);
  endtask

  task automatic test_phases();
    int pcts [4] = '{0, 60, 0, 28};
    foreach (pcts[i]) begin
      random_config();
      test_random(95, pcts[i]);
    end
  endtask

  always @(posedge clk_i) begin
    pixel_res_t exp_px, got;
    if (rst_ni && valid_o) begin
      got = '{frac_a_o, frac_b_o, frac_c_o, blended_o, dest_index_o, singular_o};
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %p", got);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (got !== exp_px) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", exp_px, got);
        end
      end
    end
  end

  initial begin
    errors = 0;
    idle_pct = 0;
    start = 1'b0;
    low_sample_i = '0;
    high_sample_i = '0;
    sample_index_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_COEF_A_LOW;
    cfg_wdata_i = '0;
    foreach (coef[i]) coef[i] = '0;
    mix_q = 16'd16384;
    base_q = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_phases();
    if (pending_pixels.size() != 0) errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
design/tmd_pkg.sv
design/tmd_front.sv
design/tmd_fifo.sv
design/tmd_div.sv
design/tmd_back.sv
design/three_material_decomposition.sv
test/three_material_decomposition_tb.sv
